### hdl/ttmc_pkg.sv
// shared types and constants for the tick to millisecond clock
package ttmc_pkg;

  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned DIVISOR_W = 23;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  localparam logic [DIVISOR_W-1:0] TICKS_PER_MS_RESET = DIVISOR_W'(709);
  localparam logic [COUNT_W-1:0]   START_COUNT_RESET  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMER_PRESENT = 2'd0,
    REG_TICKS_PER_MS  = 2'd1,
    REG_START_COUNT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/tick_to_millisecond_clock_unit.sv
// millisecond clock from samples of a free-running 32-bit tick counter
// with the timer present an accepted word runs through the 32 divider steps, then the quotient
//   is added to the total and the output loaded (held in ST_SEND while the output is stalled)
//   with the timer absent a zero result word is loaded as soon as the word is accepted
// a new word is taken only in the idle state, after the previous word's result has been loaded
// rst (synchronous, active high) restores register defaults and clears the totals
module tick_to_millisecond_clock_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ttmc_pkg::COUNT_W-1:0]    s_axis_tdata,   // [31:0] counter_low
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ttmc_pkg::COUNT_W-1:0]    m_axis_tdata,   // [31:0] elapsed_ms
  input  logic                            cfg_write,
  input  logic [ttmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttmc_pkg::CFG_W-1:0]      cfg_data
);

  localparam int unsigned CW = ttmc_pkg::COUNT_W;
  localparam int unsigned DW = ttmc_pkg::DIVISOR_W;

  ttmc_pkg::state_t    state;
  ttmc_pkg::div_stat_t div_stat;

  logic          timer_present;
  logic [DW-1:0] ticks_per_ms;
  logic [DW-1:0] divisor;
  logic [CW-1:0] previous_count;
  logic [CW-1:0] leftover_ticks;
  logic [CW-1:0] ms_total;
  logic [CW-1:0] ms_total_next;
  logic [CW-1:0] sum;
  logic [CW-1:0] quotient;
  logic [DW-1:0] remainder;
  logic          out_free;
  logic          in_accept;
  logic          div_start;

  assign divisor   = (ticks_per_ms == '0) ? DW'(1) : ticks_per_ms;
  assign sum       = leftover_ticks + (s_axis_tdata - previous_count);
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ttmc_pkg::ST_IDLE) && (timer_present || out_free);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign div_start = in_accept && timer_present;
  assign ms_total_next = ms_total + quotient;

  ttmc_div #(
    .DIVIDEND_W (CW),
    .DIVISOR_W  (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (sum),
    .divisor   (divisor),
    .stat      (div_stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ttmc_pkg::ST_IDLE;
      m_axis_tvalid  <= 1'b0;
      timer_present  <= 1'b1;
      ticks_per_ms   <= ttmc_pkg::TICKS_PER_MS_RESET;
      previous_count <= ttmc_pkg::START_COUNT_RESET;
      leftover_ticks <= '0;
      ms_total       <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (cfg_write) begin
        unique case (cfg_index)
          ttmc_pkg::REG_TIMER_PRESENT: timer_present <= cfg_data[0];
          ttmc_pkg::REG_TICKS_PER_MS:  ticks_per_ms  <= cfg_data[DW-1:0];
          ttmc_pkg::REG_START_COUNT: begin
            previous_count <= cfg_data[CW-1:0];
            leftover_ticks <= '0;
            ms_total       <= '0;
          end
          default: ;
        endcase
      end

      unique case (state)
        ttmc_pkg::ST_IDLE: begin
          if (in_accept) begin
            if (timer_present) begin
              previous_count <= s_axis_tdata;
              state          <= ttmc_pkg::ST_DIV;
            end else begin
              // timer absent: answer zero, state untouched
              m_axis_tdata  <= '0;
              m_axis_tvalid <= 1'b1;
            end
          end
        end
        ttmc_pkg::ST_DIV: begin
          if (div_stat.done) begin
            ms_total       <= ms_total_next;
            leftover_ticks <= CW'(remainder);
            if (out_free) begin
              m_axis_tdata  <= ms_total_next;
              m_axis_tvalid <= 1'b1;
              state         <= ttmc_pkg::ST_IDLE;
            end else begin
              state <= ttmc_pkg::ST_SEND;
            end
          end
        end
        ttmc_pkg::ST_SEND: begin
          if (out_free) begin
            m_axis_tdata  <= ms_total;
            m_axis_tvalid <= 1'b1;
            state         <= ttmc_pkg::ST_IDLE;
          end
        end
        default: state <= ttmc_pkg::ST_IDLE;
      endcase
    end
  end

  // divider activity tracks the divide state exactly
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    (state == ttmc_pkg::ST_DIV) == (div_stat.busy || div_stat.done))
    else $error("divider activity out of step with control state");

  // carried remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |=> (leftover_ticks < CW'(divisor)))
    else $error("leftover ticks not below divisor");

  // a word taken with the timer present starts a divide
  a_start_div: assert property (@(posedge clk) disable iff (rst)
    (in_accept && timer_present) |=> (state == ttmc_pkg::ST_DIV && div_stat.busy))
    else $error("accepted word did not start a divide");

endmodule

### hdl/ttmc_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module ttmc_div #(
  parameter int unsigned DIVIDEND_W = ttmc_pkg::COUNT_W,
  parameter int unsigned DIVISOR_W  = ttmc_pkg::DIVISOR_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output ttmc_pkg::div_stat_t   stat,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int unsigned CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        quo <= {quo[DIVIDEND_W-2:0], fits};
        rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

### verif/tick_to_millisecond_clock_unit_test.sv
// testbench for the tick to millisecond clock: predicts each running total and checks it
module tick_to_millisecond_clock_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_W   = ttmc_pkg::COUNT_W;
  localparam int unsigned DIVISOR_W = ttmc_pkg::DIVISOR_W;
  localparam int unsigned CFG_IDX_W = ttmc_pkg::CFG_IDX_W;
  localparam int unsigned CFG_W     = ttmc_pkg::CFG_W;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind this index
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 600;

  typedef enum logic [1:0] {
    TOTAL_OK,
    TOTAL_WRONG,
    TOTAL_UNEXPECTED
  } verdict_t;

  class ms_scoreboard;
    logic                 timer_on;
    logic [DIVISOR_W-1:0] tick_div;
    logic [COUNT_W-1:0]   last_count;
    logic [COUNT_W-1:0]   carry_ticks;
    logic [COUNT_W-1:0]   total_ms;
    logic [COUNT_W-1:0]   pending_totals[$];

    function new();
      timer_on    = 1'b1;
      tick_div    = ttmc_pkg::TICKS_PER_MS_RESET;
      last_count  = ttmc_pkg::START_COUNT_RESET;
      carry_ticks = '0;
      total_ms    = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        ttmc_pkg::REG_TIMER_PRESENT: timer_on = value[0];
        ttmc_pkg::REG_TICKS_PER_MS:  tick_div = value[DIVISOR_W-1:0];
        ttmc_pkg::REG_START_COUNT: begin
          last_count  = value;
          carry_ticks = '0;
          total_ms    = '0;
        end
        default: ;
      endcase
    endfunction

    function void note_sample(logic [COUNT_W-1:0] sample);
      logic [COUNT_W-1:0] divisor;
      logic [COUNT_W-1:0] ticks;
      if (!timer_on) begin
        pending_totals.push_back('0);
        return;
      end
      // a zero divisor behaves as one
      divisor = (tick_div == '0) ? 1 : COUNT_W'(tick_div);
      ticks = carry_ticks + (sample - last_count);
      last_count  = sample;
      total_ms    = total_ms + ticks / divisor;
      carry_ticks = ticks % divisor;
      pending_totals.push_back(total_ms);
    endfunction

    function verdict_t check_total(logic [COUNT_W-1:0] got, output logic [COUNT_W-1:0] want);
      want = '0;
      if (pending_totals.size() == 0) return TOTAL_UNEXPECTED;
      want = pending_totals.pop_front();
      return (got === want) ? TOTAL_OK : TOTAL_WRONG;
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [COUNT_W-1:0]   s_axis_tdata = '0;    // [31:0] counter_low
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [COUNT_W-1:0]   m_axis_tdata;         // [31:0] elapsed_ms
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  ms_scoreboard board = new();
  int unsigned  mismatch_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  hold_left = 0;
  int unsigned  gap_left = 0;
  int unsigned  quiet_cycles = 0;
  verdict_t     verdict;
  logic [COUNT_W-1:0] want_total;

  tick_to_millisecond_clock_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  task automatic report_mismatch(string what, logic [COUNT_W-1:0] got,
                                 logic [COUNT_W-1:0] want);
    $display("%0t ns: %s: got %08h, want %08h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_sample(logic [COUNT_W-1:0] sample);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    do @(posedge clk); while (!s_axis_tready);
    board.note_sample(sample);
  endtask

  task automatic offer_sample(logic [COUNT_W-1:0] sample, bit calm);
    int unsigned gap;
    send_sample(sample);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every total has come back and the divider is surely done
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_totals.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    board.write_reg(idx, value);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stalls, calm stretches, and two long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        verdict = board.check_total(m_axis_tdata, want_total);
        if (verdict == TOTAL_UNEXPECTED)
          report_mismatch("word with no total pending", m_axis_tdata, want_total);
        else if (verdict == TOTAL_WRONG)
          report_mismatch("elapsed_ms differs", m_axis_tdata, want_total);
        results_seen++;
        if (results_seen == 150 || results_seen == 1000)
          hold_left = HOLD_CYCLES;
        else if ((results_seen % 400) >= 80)
          gap_left = pick_gap();
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        m_axis_tready <= 1'b0;
        gap_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [COUNT_W-1:0] sample;
    logic [COUNT_W-1:0] last_sample;
    logic [CFG_W-1:0]   div_word;
    logic [CFG_W-1:0]   start_word;
    int unsigned        cur_div;
    int unsigned        item_total;
    int unsigned        roll;
    bit                 calm;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: whole milliseconds, carried ticks, counter wrap
    offer_sample(32'd0, 0);
    offer_sample(32'd709, 0);
    offer_sample(32'd1417, 0);
    offer_sample(32'd1418, 0);
    offer_sample(32'hFFFF_FFFF, 0);
    offer_sample(32'd5, 0);

    // divisor field of zero, reached through dropped upper bits
    settle();
    set_reg(ttmc_pkg::REG_TICKS_PER_MS, 32'hFF80_0000);
    offer_sample(32'd100, 0);
    offer_sample(32'd50, 0);

    // large carry plus near-full difference wraps before the divide
    settle();
    set_reg(ttmc_pkg::REG_TICKS_PER_MS, 32'h007F_FFFF);
    set_reg(ttmc_pkg::REG_START_COUNT, 32'h0);
    offer_sample(32'h007F_FFFE, 0);
    offer_sample(32'h007F_FFFD, 0);

    // timer absent: zeros out, state kept for when it comes back
    settle();
    set_reg(ttmc_pkg::REG_TIMER_PRESENT, 32'hFFFF_FFFE);
    offer_sample(32'd123, 0);
    offer_sample(32'hFFFF_FFFF, 0);
    settle();
    set_reg(ttmc_pkg::REG_TIMER_PRESENT, 32'd1);
    offer_sample(32'h0100_0000, 0);

    // write to an unused index must change nothing
    settle();
    set_reg(REG_SPARE, 32'h0000_0001);
    offer_sample(32'h0200_0000, 0);

    settle();
    set_reg(ttmc_pkg::REG_TICKS_PER_MS, 32'd1);
    set_reg(ttmc_pkg::REG_START_COUNT, 32'hFFFF_FFFF);
    offer_sample(32'd0, 0);
    offer_sample(32'hAAAA_AAAA, 0);
    offer_sample(32'h5555_5555, 0);

    settle();
    set_reg(ttmc_pkg::REG_TICKS_PER_MS, 32'd4294967);
    offer_sample(32'hFFFF_FFFF, 0);
    offer_sample(32'h0012_3456, 0);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       div_word = 32'd709;
        1:       div_word = 32'd1;
        2:       div_word = 32'd4294967;
        3, 4:    div_word = $urandom_range(1, 4294967);
        5:       div_word = $urandom_range(1, 1000);
        6:       div_word = $urandom();
        default: div_word = 32'h0;
      endcase
      if (phase == 0)
        start_word = '0;
      else if (phase == 2)
        start_word = '1;
      else
        start_word = $urandom();
      settle();
      set_reg(ttmc_pkg::REG_TIMER_PRESENT,
              ($urandom() & 32'hFFFF_FFFE) | CFG_W'(phase != 4));
      set_reg(ttmc_pkg::REG_TICKS_PER_MS, div_word);
      set_reg(ttmc_pkg::REG_START_COUNT, start_word);
      cur_div     = div_word[DIVISOR_W-1:0];
      last_sample = start_word;
      item_total  = (phase == 4) ? 60 : 240;
      calm        = 0;
      for (int n = 0; n < item_total; n++) begin
        if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        // mostly a counter moving forward, some noise
        roll = $urandom_range(0, 99);
        if (roll < 60)
          sample = last_sample + $urandom_range(0, 3 * cur_div + 2);
        else if (roll < 80)
          sample = last_sample + $urandom_range(0, 2000000);
        else if (roll < 88)
          sample = last_sample;
        else if (roll < 95)
          sample = last_sample + $urandom();
        else
          sample = $urandom();
        last_sample = sample;
        offer_sample(sample, calm);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ttmc_pkg.sv
hdl/ttmc_div.sv
hdl/tick_to_millisecond_clock_unit.sv
verif/tick_to_millisecond_clock_unit_test.sv
